>>> rtl/core/gsp_pkg.sv
`timescale 1ns / 1ps

package gsp_pkg;

    localparam int MAX_COLS   = 256;
    localparam int ROWS_LIMIT = 256;
    localparam int HEIGHT_W   = 16;
    localparam int SUM_W      = HEIGHT_W + 2;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(ROWS_LIMIT);
    localparam int DIM_W      = 9;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);

    typedef logic signed [HEIGHT_W-1:0] height_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [DIM_W-1:0]           dim_t;
    typedef logic [COL_W-1:0]           col_t;
    typedef logic [ROW_W-1:0]           row_t;

    // square waiting for its neighbour compare
    typedef struct packed {
        logic sr_ge2;
        logic sc_ge2;
        row_t row;
        col_t col;
    } test_t;

    function automatic dim_t clamp_dim(input dim_t value, input dim_t hi);
        dim_t res;
        if (value < DIM_MIN)
        begin
            res = DIM_MIN;
        end
        else if (value > hi)
        begin
            res = hi;
        end
        else
        begin
            res = value;
        end
        return res;
    endfunction

endpackage

>>> rtl/core/gsp_vertex_if.sv
`timescale 1ns / 1ps

interface gsp_vertex_if;
    logic                 valid;
    logic                 ready;
    gsp_pkg::height_t     height;

    modport source (output valid, output height, input ready);
    modport sink (input valid, input height, output ready);
endinterface

>>> rtl/core/gsp_peak_if.sv
`timescale 1ns / 1ps

interface gsp_peak_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           peak_row;
    logic [7:0]           peak_col;

    modport source (output valid, output peak_row, output peak_col, input ready);
    modport sink (input valid, input peak_row, input peak_col, output ready);
endinterface

>>> rtl/core/grid_square_peak_detector.sv
`timescale 1ns / 1ps
// Grid square peak detector.
// vtx (sink): one signed vertex height per beat, raster order, column fastest.
// peak (source): square row/column of each detected local maximum, zero or
//   one beat per vertex. A square is the sum of its 2x2 vertices; it is a peak
//   when every in-grid neighbour square is strictly lower. Squares are tested
//   one square behind the newest complete square; last row/column never tested.
// APB port: grid_rows at 0x0, grid_cols at 0x4, values clamped to 3..256.
//   A write restarts the frame at vertex (0,0). Write only while idle.
// Throughput: one vertex per cycle while vtx.ready is high. The vertex beat is
//   summed, the window shifted and the test stage loaded at the accepting edge,
//   and the neighbour compare runs in the next cycle; a hit then passes from the
//   test stage to the result register, which drives the peak beat. The line
//   stores are single-port-read arrays prefetched one column ahead.
// Reset: position, window, last height and both pipeline stages clear; the
//   line stores are not cleared (no clearing pass).
// Stall: while peak is held, one compared square may wait in the test stage;
//   vtx.ready falls only when the test stage holds a peak and the output is full and held.
module grid_square_peak_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    gsp_vertex_if.sink                    vtx,
    gsp_peak_if.source                    peak,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [gsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [gsp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    gsp_pkg::dim_t   grid_rows_reg;
    gsp_pkg::dim_t   grid_cols_reg;
    gsp_pkg::row_t   row_pos_reg;
    gsp_pkg::row_t   row_pos_next;
    gsp_pkg::col_t   col_pos_reg;
    gsp_pkg::col_t   col_pos_next;
    gsp_pkg::height_t last_height_reg;
    gsp_pkg::height_t up_prev_reg;
    gsp_pkg::height_t vtx_rd_reg;
    gsp_pkg::sum_t   older_rd;
    gsp_pkg::sum_t   newer_rd;
    logic [2*gsp_pkg::SUM_W-1:0] sum_rd_reg;
    gsp_pkg::sum_t   sum_window_reg [3][3];
    gsp_pkg::sum_t   square_sum;
    gsp_pkg::col_t   vtx_rd_addr;
    gsp_pkg::col_t   sum_rd_addr;
    gsp_pkg::col_t   sum_wr_addr;
    gsp_pkg::test_t  stg_reg;
    logic            stg_valid_reg;
    logic            out_valid_reg;
    logic [7:0]      out_row_reg;
    logic [7:0]      out_col_reg;
    logic            cfg_wr;
    logic            vtx_acc;
    logic            stg_adv;
    logic            peak_hit;
    logic            col_last;
    logic            row_last;
    logic            have_square;
    logic            have_test;

    gsp_pkg::height_t vtx_mem [gsp_pkg::MAX_COLS];
    logic [2*gsp_pkg::SUM_W-1:0] sum_mem [gsp_pkg::MAX_COLS-1];

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            gsp_pkg::REG_GRID_ROWS: prdata = gsp_pkg::PDATA_W'(grid_rows_reg);
            gsp_pkg::REG_GRID_COLS: prdata = gsp_pkg::PDATA_W'(grid_cols_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= gsp_pkg::dim_t'(gsp_pkg::ROWS_LIMIT);
            grid_cols_reg <= gsp_pkg::dim_t'(gsp_pkg::MAX_COLS);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == gsp_pkg::REG_GRID_ROWS)
            begin
                grid_rows_reg <= gsp_pkg::clamp_dim(pwdata[gsp_pkg::DIM_W-1:0],
                                                    gsp_pkg::dim_t'(gsp_pkg::ROWS_LIMIT));
            end
            else
            begin
                grid_cols_reg <= gsp_pkg::clamp_dim(pwdata[gsp_pkg::DIM_W-1:0],
                                                    gsp_pkg::dim_t'(gsp_pkg::MAX_COLS));
            end
        end
    end

    // handshake
    assign stg_adv   = !peak_hit || !out_valid_reg || peak.ready;
    assign vtx.ready = !stg_valid_reg || stg_adv;
    assign vtx_acc   = vtx.valid && vtx.ready;

    // raster position
    assign col_last    = ({1'b0, col_pos_reg} == grid_cols_reg - gsp_pkg::dim_t'(1));
    assign row_last    = ({1'b0, row_pos_reg} == grid_rows_reg - gsp_pkg::dim_t'(1));
    assign have_square = (row_pos_reg != '0) && (col_pos_reg != '0);
    assign have_test   = (row_pos_reg >= gsp_pkg::row_t'(2))
                         && (col_pos_reg >= gsp_pkg::col_t'(2));

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (cfg_wr)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
        end
        else if (vtx_acc)
        begin
            if (col_last)
            begin
                col_pos_next = '0;
                row_pos_next = row_last ? '0 : row_pos_reg + gsp_pkg::row_t'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + gsp_pkg::col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            last_height_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            if (cfg_wr)
            begin
                last_height_reg <= '0;
            end
            else if (vtx_acc)
            begin
                last_height_reg <= vtx.height;
            end
        end
    end

    // line stores, read one column ahead
    assign vtx_rd_addr = col_pos_next;
    assign sum_rd_addr = (col_pos_next == '0) ? '0 : col_pos_next - gsp_pkg::col_t'(1);
    assign sum_wr_addr = col_pos_reg - gsp_pkg::col_t'(1);
    assign older_rd    = sum_rd_reg[2*gsp_pkg::SUM_W-1:gsp_pkg::SUM_W];
    assign newer_rd    = sum_rd_reg[gsp_pkg::SUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (vtx_acc)
        begin
            vtx_mem[col_pos_reg] <= vtx.height;
        end
        vtx_rd_reg <= vtx_mem[vtx_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vtx_acc && have_square)
        begin
            sum_mem[sum_wr_addr] <= {newer_rd, square_sum};
        end
        sum_rd_reg <= sum_mem[sum_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vtx_acc)
        begin
            up_prev_reg <= vtx_rd_reg;
        end
    end

    assign square_sum = gsp_pkg::sum_t'(up_prev_reg) + gsp_pkg::sum_t'(vtx_rd_reg)
                        + gsp_pkg::sum_t'(last_height_reg) + gsp_pkg::sum_t'(vtx.height);

    // 3x3 window of square sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    sum_window_reg[k][m] <= '0;
                end
            end
        end
        else if (vtx_acc && have_square)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_window_reg[k][0] <= sum_window_reg[k][1];
                sum_window_reg[k][1] <= sum_window_reg[k][2];
            end
            sum_window_reg[0][2] <= older_rd;
            sum_window_reg[1][2] <= newer_rd;
            sum_window_reg[2][2] <= square_sum;
        end
    end

    // test stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (vtx_acc)
        begin
            stg_valid_reg <= have_test;
        end
        else if (stg_adv)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vtx_acc)
        begin
            stg_reg.sr_ge2 <= (row_pos_reg >= gsp_pkg::row_t'(3));
            stg_reg.sc_ge2 <= (col_pos_reg >= gsp_pkg::col_t'(3));
            stg_reg.row    <= row_pos_reg - gsp_pkg::row_t'(2);
            stg_reg.col    <= col_pos_reg - gsp_pkg::col_t'(2);
        end
    end

    always_comb
    begin
        peak_hit = stg_valid_reg;
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                if (!(k == 1 && m == 1) && (k != 0 || stg_reg.sr_ge2)
                    && (m != 0 || stg_reg.sc_ge2)
                    && (sum_window_reg[k][m] >= sum_window_reg[1][1]))
                begin
                    peak_hit = 1'b0;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (peak_hit && stg_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (peak.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (peak_hit && stg_adv)
        begin
            out_row_reg <= 8'(stg_reg.row);
            out_col_reg <= 8'(stg_reg.col);
        end
    end

    assign peak.valid    = out_valid_reg;
    assign peak.peak_row = out_row_reg;
    assign peak.peak_col = out_col_reg;

    // checks
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_pos_reg} < grid_cols_reg)
        else $error("column position outside the grid");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_pos_reg} < grid_rows_reg)
        else $error("row position outside the grid");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !stg_adv) |-> !vtx_acc)
        else $error("vertex taken while test stage blocked");

    a_peak_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stg_valid_reg))
        else $error("peak beat without a tested square");

    a_line_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
        vtx_acc |-> (vtx_rd_addr != col_pos_reg))
        else $error("vertex line read and write collide");

endmodule
